### sv/frt_pkg.sv
`default_nettype none
package frt_pkg;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPIRE = 4'b0010,
    ST_LOCATE = 4'b0100,
    ST_UPDATE = 4'b1000
  } frt_state_e;

  // Result status codes
  typedef enum logic [3:0] {
    STAT_TICK      = 4'd0,
    STAT_PARTIAL   = 4'd1,
    STAT_COMPLETE  = 4'd2,
    STAT_BAD_TOTAL = 4'd3,
    STAT_BAD_SEQ   = 4'd4,
    STAT_BAD_LEN   = 4'd5,
    STAT_NO_SLOT   = 4'd6,
    STAT_DUP       = 4'd7,
    STAT_MISMATCH  = 4'd8,
    STAT_OVERFLOW  = 4'd9
  } frt_status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAYLOAD_MAX = 2'd0;
  localparam logic [1:0] CFG_MAX_FRAGS   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_US  = 2'd2;

  // Widest slot index over the supported slot counts
  localparam int unsigned FIND_IDX_W = 4;

  // Outcome of the slot search
  typedef struct packed {
    logic                  found;  // a slot is available (hit or free)
    logic                  fresh;  // slot is newly allocated
    logic [FIND_IDX_W-1:0] idx;
  } frt_find_t;

endpackage
`default_nettype wire

### sv/frt_age_unit.sv
`default_nettype none
module frt_age_unit (
  input  wire logic        active_i,
  input  wire logic [31:0] now_i,
  input  wire logic [31:0] start_i,
  input  wire logic [31:0] timeout_i,
  output logic             expire_o
);
  logic [31:0] elapsed;

  // Age wraps modulo 2^32
  assign elapsed  = now_i - start_i;
  assign expire_o = active_i && (elapsed > timeout_i);
endmodule
`default_nettype wire

### sv/frt_slot_find.sv
`default_nettype none
module frt_slot_find #(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic [SLOTS-1:0] active_i,
  input  wire logic [7:0]       slot_msg_i [SLOTS],
  input  wire logic [7:0]       msg_i,
  output frt_pkg::frt_find_t    find_o
);
  import frt_pkg::*;

  logic                  hit;
  logic                  free;
  logic [FIND_IDX_W-1:0] hit_idx;
  logic [FIND_IDX_W-1:0] free_idx;

  // Lowest matching slot wins, else lowest free slot
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (active_i[i] && (slot_msg_i[i] == msg_i)) begin
        hit     = 1'b1;
        hit_idx = FIND_IDX_W'(i);
      end
      if (!active_i[i]) begin
        free     = 1'b1;
        free_idx = FIND_IDX_W'(i);
      end
    end
  end

  always_comb begin
    find_o.found = hit || free;
    find_o.fresh = !hit;
    find_o.idx   = hit ? hit_idx : free_idx;
  end
endmodule
`default_nettype wire

### sv/fragment_reassembly_tracker_unit.sv
`default_nettype none
// Fragment reassembly tracker. Each transaction (start high while busy is low)
// carries a time update or a fragment header plus the current microsecond
// time. The block first retires slots older than timeout_us, then validates
// the header, finds or allocates a reassembly slot and reports where the
// payload goes, or why the fragment is refused. Exactly one result comes back
// per transaction, on the result ports for a single cycle marked by done_o;
// the receiver cannot stall, so capture the result in that cycle. The
// expiry scan steps one slot per cycle through a single shared 32-bit age
// comparator, then the locate state finds the slot and the update state
// checks and updates it. busy drops in the cycle done_o is high, so a new
// transaction may be issued then and is taken at the end of that cycle.
// Configuration writes are always taken (cfg_ready_o is tied high);
// write them only while the block is idle. Register index 3 is ignored.
module fragment_reassembly_tracker_unit #(
  parameter int unsigned SLOTS     = 4,
  parameter int unsigned BUF_BYTES = 2048,
  parameter int unsigned SEQ_BITS  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [31:0] now_us_i,
  input  wire logic [7:0]  msg_id_i,
  input  wire logic [7:0]  frag_seq_i,
  input  wire logic [7:0]  total_frags_i,
  input  wire logic [7:0]  payload_len_i,
  // result
  output logic             done_o,
  output logic [3:0]       status_o,
  output logic [1:0]       slot_index_o,
  output logic [11:0]      write_offset_o,
  output logic [4:0]       write_len_o,
  output logic [12:0]      message_len_o,
  output logic [3:0]       expired_mask_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import frt_pkg::*;

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SEQ_W  = $clog2(SEQ_BITS);
  localparam logic [6:0]  SEQ_LIM = 7'(SEQ_BITS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [13:0] BUF_LIM = 14'(BUF_BYTES);

  // Configuration registers
  logic [4:0]  pay_max_q;
  logic [6:0]  max_frags_q;
  logic [31:0] timeout_q;

  // Latched transaction
  logic        req_q;
  logic [31:0] now_q;
  logic [7:0]  msg_q;
  logic [7:0]  seq_q;
  logic [7:0]  total_q;
  logic [7:0]  len_q;

  // Sequencer
  frt_state_e        state_q, state_d;
  logic [SLOT_W-1:0] scan_q;
  logic [3:0]        exp_q;

  // Slot table; active is control, the rest is written by each fragment update
  logic [SLOTS-1:0]    active_q;
  logic [7:0]          slot_msg_q    [SLOTS];
  logic [6:0]          slot_total_q  [SLOTS];
  logic [6:0]          slot_count_q  [SLOTS];
  logic [31:0]         slot_start_q  [SLOTS];
  logic [SEQ_BITS-1:0] slot_seen_q   [SLOTS];
  logic [12:0]         slot_length_q [SLOTS];

  // Locate results
  logic              pre_ok_q;
  logic              fresh_q;
  logic [SLOT_W-1:0] slot_q;
  frt_status_e       pre_stat_q;

  // Result registers
  logic        done_q;
  frt_status_e status_q;
  logic [1:0]  slot_index_q;
  logic [11:0] woff_q;
  logic [4:0]  wlen_q;
  logic [12:0] mlen_q;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Expiry scan: one slot per cycle through the shared age comparator
  // ---------------------------------------------------------------------
  logic age_expire;

  frt_age_unit u_age (
    .active_i  (active_q[scan_q]),
    .now_i     (now_q),
    .start_i   (slot_start_q[scan_q]),
    .timeout_i (timeout_q),
    .expire_o  (age_expire)
  );

  // ---------------------------------------------------------------------
  // Header validation and slot search
  // ---------------------------------------------------------------------
  logic [6:0] limit;
  logic       bad_total;
  logic       bad_seq;
  logic       bad_len;
  frt_find_t  find;

  assign limit     = (max_frags_q < SEQ_LIM) ? max_frags_q : SEQ_LIM;
  assign bad_total = (total_q == 8'd0) || ({1'b0, limit} < total_q);
  assign bad_seq   = (seq_q >= total_q);
  assign bad_len   = (len_q == 8'd0) || ({3'b000, pay_max_q} < len_q);

  frt_slot_find #(
    .SLOTS (SLOTS)
  ) u_find (
    .active_i   (active_q),
    .slot_msg_i (slot_msg_q),
    .msg_i      (msg_q),
    .find_o     (find)
  );

  // ---------------------------------------------------------------------
  // Slot check and update
  // ---------------------------------------------------------------------
  logic [SEQ_W-1:0]    seq_idx;
  logic [SEQ_BITS-1:0] seq_bit;
  logic [SEQ_BITS-1:0] seen_cur;
  logic [6:0]          total_cur;
  logic [6:0]          count_cur;
  logic [12:0]         length_cur;
  logic                dup;
  logic                mism;
  logic [12:0]         off;
  logic [13:0]         need;
  logic                ovf;
  logic                good;
  logic [6:0]          count_new;
  logic [12:0]         length_new;
  logic                cmpl;
  frt_status_e         upd_stat;

  assign seq_idx = seq_q[SEQ_W-1:0];
  assign seq_bit = {{(SEQ_BITS-1){1'b0}}, 1'b1} << seq_idx;

  // A fresh slot reads as cleared
  assign seen_cur   = fresh_q ? '0 : slot_seen_q[slot_q];
  assign total_cur  = fresh_q ? '0 : slot_total_q[slot_q];
  assign count_cur  = fresh_q ? '0 : slot_count_q[slot_q];
  assign length_cur = fresh_q ? '0 : slot_length_q[slot_q];

  assign dup  = seen_cur[seq_idx];
  assign mism = (total_cur != 7'd0) && (total_cur != total_q[6:0]);
  assign off  = 13'(seq_q) * 13'(pay_max_q);
  assign need = 14'(off) + 14'(len_q);
  assign ovf  = need > BUF_LIM;
  assign good = !dup && !mism && !ovf;

  assign count_new  = count_cur + 7'd1;
  assign length_new = (need[12:0] > length_cur) ? need[12:0] : length_cur;
  assign cmpl       = (count_new == total_q[6:0]);

  always_comb begin
    if (dup) begin
      upd_stat = STAT_DUP;
    end else if (mism) begin
      upd_stat = STAT_MISMATCH;
    end else if (ovf) begin
      upd_stat = STAT_OVERFLOW;
    end else if (cmpl) begin
      upd_stat = STAT_COMPLETE;
    end else begin
      upd_stat = STAT_PARTIAL;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (scan_q == LAST_SLOT) begin
          state_d = ST_LOCATE;
        end
      end
      ST_LOCATE: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      active_q    <= '0;
      done_q      <= 1'b0;
      pay_max_q   <= 5'd28;
      max_frags_q <= 7'd64;
      timeout_q   <= 32'd1000000;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_UPDATE);

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PAYLOAD_MAX: pay_max_q   <= cfg_data_i[4:0];
          CFG_MAX_FRAGS:   max_frags_q <= cfg_data_i[6:0];
          CFG_TIMEOUT_US:  timeout_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (accept) begin
        scan_q <= '0;
      end else if (state_q == ST_EXPIRE) begin
        // drop the scanned slot if it has aged out
        if (age_expire) begin
          active_q[scan_q] <= 1'b0;
        end
        scan_q <= scan_q + SLOT_W'(1);
      end

      // hold the slot while unfinished, free it on completion or overflow
      if ((state_q == ST_UPDATE) && pre_ok_q) begin
        active_q[slot_q] <= !(ovf || (good && cmpl)) || dup || mism;
      end
    end
  end

  // Transaction and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      now_q   <= now_us_i;
      msg_q   <= msg_id_i;
      seq_q   <= frag_seq_i;
      total_q <= total_frags_i;
      len_q   <= payload_len_i;
      exp_q   <= '0;
    end else if ((state_q == ST_EXPIRE) && age_expire) begin
      // slots beyond the fourth have no mask bit
      exp_q <= exp_q | (4'd1 << scan_q);
    end

    if (state_q == ST_LOCATE) begin
      fresh_q  <= find.fresh;
      slot_q   <= find.idx[SLOT_W-1:0];
      pre_ok_q <= req_q && !bad_total && !bad_seq && !bad_len && find.found;
      if (!req_q) begin
        pre_stat_q <= STAT_TICK;
      end else if (bad_total) begin
        pre_stat_q <= STAT_BAD_TOTAL;
      end else if (bad_seq) begin
        pre_stat_q <= STAT_BAD_SEQ;
      end else if (bad_len) begin
        pre_stat_q <= STAT_BAD_LEN;
      end else if (!find.found) begin
        pre_stat_q <= STAT_NO_SLOT;
      end else begin
        pre_stat_q <= STAT_PARTIAL;
      end
    end

    // Advance the slot record and build the result
    if (state_q == ST_UPDATE) begin
      if (pre_ok_q) begin
        status_q     <= upd_stat;
        slot_index_q <= 2'(slot_q);
        woff_q       <= good ? off[11:0] : '0;
        wlen_q       <= good ? len_q[4:0] : '0;
        mlen_q       <= (good && cmpl) ? length_new : '0;

        slot_msg_q[slot_q] <= msg_q;
        if (fresh_q) begin
          slot_start_q[slot_q] <= now_q;
        end
        slot_total_q[slot_q]  <= (dup || mism) ? total_cur : total_q[6:0];
        slot_seen_q[slot_q]   <= good ? (seen_cur | seq_bit) : seen_cur;
        slot_count_q[slot_q]  <= good ? count_new : count_cur;
        slot_length_q[slot_q] <= good ? length_new : length_cur;
      end else begin
        status_q     <= pre_stat_q;
        slot_index_q <= '0;
        woff_q       <= '0;
        wlen_q       <= '0;
        mlen_q       <= '0;
      end
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_index_q;
  assign write_offset_o = woff_q;
  assign write_len_o    = wlen_q;
  assign message_len_o  = mlen_q;
  assign expired_mask_o = exp_q;
endmodule
`default_nettype wire
